/* design/stbs_pkg.sv */
// Package for the sorted-table binary search unit: transaction structs,
// controller/datapath command and status structs, codes and field widths.
// No dependencies.
package stbs_pkg;

    localparam int CNT_W      = 9;
    localparam int IDX_W      = 8;
    localparam int FIELD_KW   = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic REG_TABLE_COUNT = 1'b0;
    localparam logic REG_FIRST_MATCH = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [IDX_W-1:0]    entry_index;
        logic [FIELD_KW-1:0] entry_value;
        logic [FIELD_KW-1:0] search_key;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic range_empty;
        logic key_eq;
    } dp_status_t;

endpackage

/* design/stbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/stbs_dpath.sv */
// Bisection datapath: search key, low/high bounds, hit record, key table RAM
// and result register. Depends on stbs_pkg and stbs_ram.
module stbs_dpath #(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stbs_pkg::ctrl_cmd_t         cmd,
    output stbs_pkg::dp_status_t        status,
    input  logic                        wr_en,
    input  logic [stbs_pkg::IDX_W-1:0]  wr_index,
    input  logic [stbs_pkg::FIELD_KW-1:0] wr_value,
    input  logic [stbs_pkg::FIELD_KW-1:0] search_key,
    input  logic [stbs_pkg::CNT_W-1:0]  table_count,
    output stbs_pkg::out_item_t         result
);
    import stbs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic                 hit_reg, hit_next;
    logic [CNT_W-1:0]     hit_idx_reg, hit_idx_next;
    out_item_t            result_reg;

    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid;
    logic [KEY_WIDTH-1:0] rdata;
    logic                 key_lt;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W+1)'(1);
    assign mid     = mid_sum[CNT_W:1];

    stbs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_key_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(wr_index)),
        .wdata (KEY_WIDTH'(wr_value)),
        .raddr (AW'(mid)),
        .rdata (rdata)
    );

    assign key_lt             = rdata < key_reg;
    assign status.key_eq      = rdata == key_reg;
    assign status.range_empty = lo_reg >= hi_reg;

    always_comb
    begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        if (cmd.start)
        begin
            lo_next  = '0;
            hi_next  = table_count;
            hit_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (status.key_eq)
            begin
                hit_next     = 1'b1;
                hit_idx_next = mid;
                hi_next      = mid;
            end
            else if (key_lt)
            begin
                lo_next = mid + CNT_W'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= '0;
            hi_reg  <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg <= hit_idx_next;
        if (cmd.start)
        begin
            key_reg <= KEY_WIDTH'(search_key);
        end
        if (cmd.load_out)
        begin
            result_reg.found       <= hit_reg;
            result_reg.match_index <= hit_reg ? hit_idx_reg[IDX_W-1:0] : '0;
        end
    end

    assign result = result_reg;

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("low bound passed high bound");

    a_step_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && !status.key_eq |=> (hi_reg - lo_reg) < $past(hi_reg - lo_reg))
        else $error("bisection step did not narrow the range");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && status.key_eq |=> hit_reg && hit_idx_reg < $past(hi_reg))
        else $error("hit index outside the searched range");

endmodule

/* design/stbs_ctrl.sv */
// Search controller: state machine sequencing probe and compare cycles and
// owning the result valid flag. Depends on stbs_pkg.
module stbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    output logic                 in_stall,
    input  logic                 first_match_mode,
    input  stbs_pkg::dp_status_t status,
    output stbs_pkg::ctrl_cmd_t  cmd,
    output logic                 out_valid,
    input  logic                 out_stall
);
    import stbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_COMPARE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.start    = (state_reg == S_IDLE) && in_valid && (in_cmd == CMD_SEARCH);
        cmd.step     = (state_reg == S_COMPARE);
        cmd.load_out = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = status.range_empty ? S_FINISH : S_COMPARE;
            end
            S_COMPARE:
            begin
                if (status.key_eq && !first_match_mode)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end
            S_FINISH:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while held");

    a_start_probes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == S_PROBE)
        else $error("search start did not enter probe");

    a_load_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result load did not present a result");

endmodule

/* design/sorted_table_binary_search_unit.sv */
// Sorted-table binary search unit, top level: APB configuration registers,
// controller and datapath. Depends on stbs_pkg, stbs_ctrl, stbs_dpath.
//
// Usage: input transactions arrive on in_valid/in_stall/in_data. A load
// (cmd 0) writes entry_value to entry_index and gives no result; indexes
// at or above DEPTH are dropped. A search (cmd 1) bisects the first
// table_count entries and gives one result on out_valid/out_stall/
// out_data: found and match_index (zero on a miss or an empty table).
// first_match_mode selects any match met by bisection or the leftmost match.
// Each probe is a range check and RAM read in the probe state and a compare
// in the compare state; a search ends when the range check finds the range
// empty, or on an any-match hit, and then loads the result. A search makes
// at most floor(log2(table_count))+1 probes. Once the result is loaded the
// next transaction is taken; loads are taken back to back.
// in_stall is high while a search is in progress. A finished result waits
// in the output register while out_stall is high; the next transaction is
// accepted meanwhile, and a later result waits until the register is free.
// Reset clears table_count and first_match_mode and empties the output;
// table contents are undefined until loaded.
module sorted_table_binary_search_unit #(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  stbs_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output stbs_pkg::out_item_t               out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stbs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [stbs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [stbs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import stbs_pkg::*;

    logic [CNT_W-1:0] table_count_reg;
    logic             first_match_reg;
    logic             cfg_wr;
    logic             reg_sel;
    logic [CNT_W-1:0] count_wr;
    logic             load_wr;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];
    assign count_wr = (32'(pwdata[CNT_W-1:0]) > DEPTH) ? CNT_W'(DEPTH)
                                                      : pwdata[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_count_reg <= '0;
            first_match_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_TABLE_COUNT: table_count_reg <= count_wr;
                REG_FIRST_MATCH: first_match_reg <= pwdata[0];
                default:         table_count_reg <= table_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_TABLE_COUNT: prdata = CFG_DATA_W'(table_count_reg);
            REG_FIRST_MATCH: prdata = CFG_DATA_W'(first_match_reg);
            default:         prdata = '0;
        endcase
    end

    assign load_wr = in_valid && !in_stall && (in_data.cmd == CMD_LOAD)
                     && (32'(in_data.entry_index) < DEPTH);

    stbs_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_cmd           (in_data.cmd),
        .in_stall         (in_stall),
        .first_match_mode (first_match_reg),
        .status           (status),
        .cmd              (cmd),
        .out_valid        (out_valid),
        .out_stall        (out_stall)
    );

    stbs_dpath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .wr_en       (load_wr),
        .wr_index    (in_data.entry_index),
        .wr_value    (in_data.entry_value),
        .search_key  (in_data.search_key),
        .table_count (table_count_reg),
        .result      (out_data)
    );

endmodule

/* verif/search_result_checker.sv */
// Checker for the sorted-table binary search unit: follows the APB writes and
// the input channel, predicts each lookup result and compares it on the output.
// Depends on stbs_pkg.
module search_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  stbs_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  stbs_pkg::out_item_t             out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [stbs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [stbs_pkg::CFG_DATA_W-1:0] pwdata,
    output int                              fail_count,
    output int                              outstanding,
    output int                              results_seen,
    output int                              hits_seen,
    output int                              loads_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int TABLE_DEPTH = 1 << IDX_W;

    logic [FIELD_KW-1:0] table_copy [TABLE_DEPTH];
    logic [CNT_W-1:0]    used_count;
    logic                leftmost_mode;
    out_item_t           expected_lookups [$];
    int                  failures;
    int                  results;
    int                  hits;
    int                  loads;

    function automatic out_item_t predict_lookup(logic [FIELD_KW-1:0] key);
        int        lo;
        int        hi;
        int        mid;
        int        hit;
        out_item_t res;
        lo  = 0;
        hi  = int'(used_count) - 1;
        hit = -1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (table_copy[mid] == key)
            begin
                hit = mid;
                hi  = leftmost_mode ? mid - 1 : -1;
            end
            else if (table_copy[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        res.found       = (hit >= 0);
        res.match_index = (hit >= 0) ? IDX_W'(hit) : '0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t        want;
        logic [CNT_W-1:0] count_raw;
        if (!rst_n)
        begin
            used_count    = '0;
            leftmost_mode = 1'b0;
            expected_lookups.delete();
            failures = 0;
            results  = 0;
            hits     = 0;
            loads    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[CFG_ADDR_W-1:2] == REG_TABLE_COUNT)
                begin
                    count_raw  = pwdata[CNT_W-1:0];
                    used_count = (count_raw > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_raw;
                end
                else
                    leftmost_mode = pwdata[0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_lookups.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result found=%0b index=%0d, none expected",
                             $time, out_data.found, out_data.match_index);
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    results++;
                    if (want.found)
                        hits++;
                    if (out_data.found !== want.found)
                    begin
                        failures++;
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, out_data.found);
                    end
                    if (out_data.match_index !== want.match_index)
                    begin
                        failures++;
                        $display("%0t: match_index expected %0d actual %0d",
                                 $time, want.match_index, out_data.match_index);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.cmd == CMD_LOAD)
                begin
                    table_copy[in_data.entry_index] = in_data.entry_value;
                    loads++;
                end
                else
                    expected_lookups.push_back(predict_lookup(in_data.search_key));
            end
        end
        fail_count   <= failures;
        outstanding  <= expected_lookups.size();
        results_seen <= results;
        hits_seen    <= hits;
        loads_seen   <= loads;
    end

endmodule

/* verif/sorted_table_binary_search_unit_test.sv */
// Testbench top for the sorted-table binary search unit: clock, reset, APB
// set-up, table loads and lookups with random idling, and the verdict.
// Depends on stbs_pkg, sorted_table_binary_search_unit, search_result_checker.
module sorted_table_binary_search_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    outstanding;
    int                    results_seen;
    int                    hits_seen;
    int                    loads_seen;
    int                    cycle_count = 0;
    int                    stall_run   = 0;
    bit                    idling_on   = 1'b1;
    logic [FIELD_KW-1:0]   key_shadow [1 << IDX_W];

    sorted_table_binary_search_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    search_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .hits_seen    (hits_seen),
        .loads_seen   (loads_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else if (idling_on && !out_stall && $urandom_range(0, 99) < 40)
        begin
            out_stall <= 1'b1;
            stall_run <= gap_length();
        end
        else
        begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(0, 8);
        end
    end

    task automatic send_item(in_item_t item);
        int gap;
        gap = (idling_on && $urandom_range(0, 1)) ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic load_entry(int idx, logic [FIELD_KW-1:0] value);
        in_item_t item;
        item.cmd         = CMD_LOAD;
        item.entry_index = IDX_W'(idx);
        item.entry_value = value;
        item.search_key  = $urandom();
        key_shadow[idx]  = value;
        send_item(item);
    endtask

    task automatic lookup(logic [FIELD_KW-1:0] key);
        in_item_t item;
        item.cmd         = CMD_SEARCH;
        item.entry_index = IDX_W'($urandom());
        item.entry_value = $urandom();
        item.search_key  = key;
        send_item(item);
    endtask

    task automatic apb_write(logic reg_sel, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int count_value, logic leftmost);
        logic [CFG_DATA_W-1:0] junk;
        drain();
        junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        apb_write(REG_TABLE_COUNT, (junk & ~32'h1FF) | CFG_DATA_W'(count_value));
        junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        apb_write(REG_FIRST_MATCH, (junk & ~32'h1) | CFG_DATA_W'(leftmost));
    endtask

    initial
    begin
        int                  random_items;
        int                  phase;
        int                  count_value;
        int                  used;
        int                  style;
        int                  lookups;
        int                  lead;
        int                  trail;
        int                  i;
        int                  r;
        bit                  refill;
        logic [FIELD_KW-1:0] value;
        logic [FIELD_KW-1:0] key;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table straight out of reset
        lookup(32'h0);
        load_entry(0, 32'h0);
        load_entry(1, 32'h7);
        load_entry(2, 32'h7);
        load_entry(3, 32'h7);
        load_entry(4, 32'hFFFF_FFFF);
        configure(5, 1'b0);
        lookup(32'h0);
        lookup(32'h7);
        lookup(32'hFFFF_FFFF);
        lookup(32'h8);
        lookup(32'h3);
        configure(5, 1'b1);
        lookup(32'h7);
        lookup(32'h0);
        lookup(32'hFFFF_FFFF);
        configure(1, 1'b1);
        lookup(32'h0);
        lookup(32'h7);
        configure(0, 1'b1);
        lookup(32'h7);

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (phase == 0)
                count_value = 256;
            else if (phase == 1)
                count_value = 511;
            else if (r < 10)
                count_value = 0;
            else if (r < 40)
                count_value = $urandom_range(1, 8);
            else if (r < 70)
                count_value = $urandom_range(9, 40);
            else if (r < 80)
                count_value = $urandom_range(41, 255);
            else if (r < 88)
                count_value = 256;
            else
                count_value = $urandom_range(257, 511);
            used      = (count_value > 256) ? 256 : count_value;
            idling_on <= (phase < 2) || ($urandom_range(0, 4) != 0);
            configure(count_value, 1'($urandom_range(0, 1)));

            refill = (phase == 0) || (used <= 40) || ($urandom_range(0, 3) == 0);
            style  = $urandom_range(0, 99);
            lead   = $urandom_range(0, used / 4);
            trail  = $urandom_range(0, used / 4);
            value  = (style < 35) ? $urandom_range(1, 32'hFFFF_0000) : $urandom_range(1, 1 << 20);
            for (i = 0; refill && i < used; i++)
            begin
                if (style < 35)
                    value += $urandom_range(0, 2);
                else
                    value += $urandom_range(0, 1 << 22);
                if (style >= 85)
                    load_entry(i, $urandom());
                else if (style >= 65 && i < lead)
                    load_entry(i, 32'h0);
                else if (style >= 65 && i >= used - trail)
                    load_entry(i, 32'hFFFF_FFFF);
                else
                    load_entry(i, value);
                random_items++;
            end

            lookups = (used == 0) ? 10 : $urandom_range(20, 60);
            for (i = 0; i < lookups; i++)
            begin
                r = $urandom_range(0, 99);
                if (used == 0 && r >= 5 && r < 72)
                    r = 72;
                if (r < 5)
                    load_entry($urandom_range(0, 255), $urandom());
                else
                begin
                    if (r < 60)
                        key = key_shadow[$urandom_range(0, used - 1)];
                    else if (r < 72)
                        key = key_shadow[$urandom_range(0, used - 1)]
                              + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
                    else if (r < 86)
                        key = $urandom();
                    else if (r < 93)
                        key = 32'h0;
                    else
                        key = 32'hFFFF_FFFF;
                    lookup(key);
                end
                random_items++;
            end
            phase++;
        end

        drain();
        $display("Ran %0d table loads and %0d lookups (%0d hits) over %0d random settings",
                 loads_seen, results_seen, hits_seen, phase);
        $display("Covered both match modes, empty to saturated counts, sorted and unsorted tables");
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
